### sv/hill_cipher_block_transform_defines.svh
// Assertion macros used by the Hill cipher block transform checker.
`ifndef HILL_CIPHER_BLOCK_TRANSFORM_DEFINES_SVH
`define HILL_CIPHER_BLOCK_TRANSFORM_DEFINES_SVH

// Consequent checked in the cycle after the antecedent, ignored while in reset.
`define HCBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define HCBT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

// State seen in the cycle after reset is asserted.
`define HCBT_ASSERT_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

### sv/hcbt_pkg.sv
// Types, constants and the modulo-26 helper for the Hill cipher block transform.
`default_nettype none

package hcbt_pkg;

  // Field widths
  localparam int LETTER_W     = 5;
  localparam int KEY_ROWS     = 4;
  localparam int KEY_ROW_W    = KEY_ROWS * LETTER_W;
  localparam int BLOCK_SIZE_W = 3;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = KEY_ROW_W;

  // Defaults
  localparam int MAX_BLOCK_DEFAULT = 4;
  localparam int BLOCK_SIZE_RESET  = 3;

  // Alphabet
  localparam int ALPHABET   = 26;
  localparam int PAD_LETTER = 23;  // 'x'

  // Dot product of up to four 5-bit by 5-bit terms
  localparam int SUM_W = 2 * LETTER_W + 2;

  // x mod 26 via reciprocal: q = (x * 2521) >> 16 is exact for x < 4096
  localparam int MOD_RECIP = 2521;
  localparam int MOD_SHIFT = 16;
  localparam int SCALED_W  = SUM_W + MOD_SHIFT;
  localparam int QUOT_W    = 8;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BLOCK_SIZE    = 3'd0,
    REG_KEY_ROW_ZERO  = 3'd1,
    REG_KEY_ROW_ONE   = 3'd2,
    REG_KEY_ROW_TWO   = 3'd3,
    REG_KEY_ROW_THREE = 3'd4
  } cfg_reg_t;

  // Input transaction
  typedef struct packed {
    logic [LETTER_W-1:0] letter_in;
    logic                message_end;
  } text_t;

  // Output transaction
  typedef struct packed {
    logic [LETTER_W-1:0] letter_out;
    logic                block_last;
    logic                message_last;
  } cipher_t;

  // Reduce a dot-product sum modulo 26
  function automatic logic [LETTER_W-1:0] mod_alphabet(input logic [SUM_W-1:0] x);
    logic [SCALED_W-1:0] scaled;
    logic [QUOT_W-1:0]   q;
    logic [SUM_W-1:0]    r;
    scaled = SCALED_W'(x) * SCALED_W'(MOD_RECIP);
    q      = scaled[MOD_SHIFT +: QUOT_W];
    r      = x - SUM_W'(q) * SUM_W'(ALPHABET);
    return r[LETTER_W-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/hcbt_mix.sv
// Key matrix times letter block, each row reduced modulo 26.
`default_nettype none

module hcbt_mix #(
  parameter int DEPTH = hcbt_pkg::KEY_ROWS,
  parameter int CNT_W = 3
) (
  input  wire logic [DEPTH-1:0][hcbt_pkg::LETTER_W-1:0]  block,
  input  wire logic [CNT_W-1:0]                          size,
  input  wire logic [DEPTH-1:0][hcbt_pkg::KEY_ROW_W-1:0] key_rows,
  output logic      [DEPTH-1:0][hcbt_pkg::LETTER_W-1:0]  letters
);

  localparam int LW    = hcbt_pkg::LETTER_W;
  localparam int SUM_W = hcbt_pkg::SUM_W;

  // One dot product per row; columns at or past the block size are masked
  always_comb begin
    logic [2*LW-1:0]  prod;
    logic [SUM_W-1:0] acc;
    prod = '0;
    acc  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      acc = '0;
      for (int j = 0; j < DEPTH; j++) begin
        prod = key_rows[i][j*LW +: LW] * block[j];
        if (CNT_W'(j) < size) begin
          acc = acc + SUM_W'(prod);
        end
      end
      letters[i] = hcbt_pkg::mod_alphabet(acc);
    end
  end

endmodule

`default_nettype wire

### sv/hill_cipher_block_transform.sv
// Hill cipher block transform: letter collection, matrix product, result drain.
// A completed block is registered, then its product lands in the result buffer.
// Throughput: one letter accepted and one result out per cycle while not stalled.
// A block closed early by message end can stall input while the result buffer drains.
// Reset (synchronous): fill count and valids cleared, block size 3, key rows 0.
// The letter store is not reset; only written entries are read.
`default_nettype none

module hill_cipher_block_transform #(
  parameter int MAX_BLOCK = hcbt_pkg::MAX_BLOCK_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // letter stream
  input  wire logic                             text_valid,
  output logic                                  text_stall,
  input  wire hcbt_pkg::text_t                  text,
  // transformed letters
  output logic                                  cipher_valid,
  input  wire logic                             cipher_stall,
  output hcbt_pkg::cipher_t                     cipher,
  // configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [hcbt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [hcbt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH = (MAX_BLOCK < hcbt_pkg::KEY_ROWS) ? MAX_BLOCK : hcbt_pkg::KEY_ROWS;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LW    = hcbt_pkg::LETTER_W;
  localparam int BS_W  = hcbt_pkg::BLOCK_SIZE_W;
  localparam int KW    = hcbt_pkg::KEY_ROW_W;
  localparam int CI_W  = hcbt_pkg::CFG_INDEX_W;

  // Configuration registers
  logic [BS_W-1:0]            block_size;
  logic [DEPTH-1:0][KW-1:0]   key_rows;
  logic [CI_W-1:0]            key_sel;

  // Collection
  logic [DEPTH-1:0][LW-1:0]   store;
  logic [IDX_W-1:0]           count;
  logic [CNT_W-1:0]           count_inc;
  logic [CNT_W-1:0]           size_eff;
  logic                       text_accept;
  logic                       block_done;
  logic [DEPTH-1:0][LW-1:0]   blk_next;

  // Block register feeding the matrix product
  logic                       blk_valid;
  logic [DEPTH-1:0][LW-1:0]   blk_letters;
  logic [CNT_W-1:0]           blk_n;
  logic                       blk_end;
  logic                       blk_move;

  // Result buffer
  logic                       res_valid;
  logic [DEPTH-1:0][LW-1:0]   res_letters;
  logic [DEPTH-1:0][LW-1:0]   mix_letters;
  logic [CNT_W-1:0]           res_n;
  logic                       res_end;
  logic [IDX_W-1:0]           rd;
  logic                       res_last;
  logic                       cipher_accept;
  logic                       res_free;

  // Configuration port always takes writes
  assign cfg_ready = 1'b1;
  assign key_sel   = cfg_index - CI_W'(hcbt_pkg::REG_KEY_ROW_ZERO);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BS_W'(hcbt_pkg::BLOCK_SIZE_RESET);
      key_rows   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index) inside
        hcbt_pkg::REG_BLOCK_SIZE: begin
          block_size <= cfg_data[BS_W-1:0];
        end
        hcbt_pkg::REG_KEY_ROW_ZERO, hcbt_pkg::REG_KEY_ROW_ONE,
        hcbt_pkg::REG_KEY_ROW_TWO, hcbt_pkg::REG_KEY_ROW_THREE: begin
          // rows past the supported block size are not stored
          for (int r = 0; r < DEPTH; r++) begin
            if (key_sel == CI_W'(r)) begin
              key_rows[r] <= cfg_data;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Block size in use: zero acts as one, large values saturate
  always_comb begin
    if (block_size == '0) begin
      size_eff = CNT_W'(1);
    end else if (block_size > BS_W'(DEPTH)) begin
      size_eff = CNT_W'(DEPTH);
    end else begin
      size_eff = CNT_W'(block_size);
    end
  end

  // Handshake and drain control
  assign res_last      = (CNT_W'(rd) + CNT_W'(1)) == res_n;
  assign cipher_accept = res_valid && !cipher_stall;
  assign res_free      = !res_valid || (cipher_accept && res_last);
  assign blk_move      = blk_valid && res_free;
  assign text_stall    = blk_valid && !blk_move;
  assign text_accept   = text_valid && !text_stall;

  assign count_inc  = CNT_W'(count) + CNT_W'(1);
  assign block_done = text.message_end || (count_inc >= size_eff);

  // Completed block: stored letters, the new letter, then pad
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      if (IDX_W'(j) == count) begin
        blk_next[j] = text.letter_in;
      end else if (CNT_W'(j) < CNT_W'(count)) begin
        blk_next[j] = store[j];
      end else begin
        blk_next[j] = LW'(hcbt_pkg::PAD_LETTER);
      end
    end
  end

  // Matrix product on the held block
  hcbt_mix #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_mix (
    .block    (blk_letters),
    .size     (blk_n),
    .key_rows (key_rows),
    .letters  (mix_letters)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      blk_valid <= 1'b0;
      res_valid <= 1'b0;
      rd        <= '0;
    end else begin
      if (text_accept) begin
        count <= block_done ? '0 : count_inc[IDX_W-1:0];
      end
      if (text_accept && block_done) begin
        blk_valid <= 1'b1;
      end else if (blk_move) begin
        blk_valid <= 1'b0;
      end
      if (blk_move) begin
        res_valid <= 1'b1;
        rd        <= '0;
      end else if (cipher_accept) begin
        if (res_last) begin
          res_valid <= 1'b0;
        end else begin
          rd <= rd + IDX_W'(1);
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (text_accept) begin
      store[count] <= text.letter_in;
    end
    if (text_accept && block_done) begin
      blk_letters <= blk_next;
      blk_n       <= size_eff;
      blk_end     <= text.message_end;
    end
    if (blk_move) begin
      res_letters <= mix_letters;
      res_n       <= blk_n;
      res_end     <= blk_end;
    end
  end

  // Output transaction
  assign cipher_valid        = res_valid;
  assign cipher.letter_out   = res_letters[rd];
  assign cipher.block_last   = res_last;
  assign cipher.message_last = res_last && res_end;

endmodule

`default_nettype wire

### sv/hcbt_check.sv
// Port-level assertion checker for the Hill cipher block transform, with its bind.
`default_nettype none
`include "hill_cipher_block_transform_defines.svh"

module hcbt_check (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              text_stall,
  input wire logic              cipher_valid,
  input wire logic              cipher_stall,
  input wire hcbt_pkg::cipher_t cipher
);

  // Reset leaves no result pending and the input open
  `HCBT_ASSERT_RESET(a_reset_idle, !cipher_valid && !text_stall, "not idle after reset")

  // Message end only marks the closing letter of a block
  `HCBT_ASSERT_NOW(a_msg_on_block, !rst && cipher_valid && cipher.message_last,
                   cipher.block_last, "message_last without block_last")

  // Input is held back only while results are waiting to leave
  `HCBT_ASSERT_NOW(a_stall_cause, !rst && text_stall, cipher_valid,
                   "input stalled with no result pending")

  // Letters of one block leave without gaps
  `HCBT_ASSERT_NEXT(a_block_gapless, cipher_valid && !cipher_stall && !cipher.block_last,
                    cipher_valid, "gap inside an emitted block")

  // A stalled result transaction holds
  `HCBT_ASSERT_NEXT(a_out_hold, cipher_valid && cipher_stall,
                    cipher_valid && $stable(cipher), "stalled result changed")

endmodule

bind hill_cipher_block_transform hcbt_check u_check (.*);

`default_nettype wire

### tb/sv/hill_block_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the Hill cipher block transform: predicts each emitted block and checks results.
module hill_block_checker #(
  parameter int MAX_BLOCK = hcbt_pkg::MAX_BLOCK_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             text_valid,
  input  logic                             text_stall,
  input  hcbt_pkg::text_t                  text,
  input  logic                             cipher_valid,
  input  logic                             cipher_stall,
  input  hcbt_pkg::cipher_t                cipher,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [hcbt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hcbt_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               expected_pending,
  output int                               failures,
  output int                               results_checked
);
  import hcbt_pkg::*;

  // shadow of the block's registers and letter buffer
  logic [BLOCK_SIZE_W-1:0] size_setting;
  logic [KEY_ROW_W-1:0]    key_row [KEY_ROWS];
  logic [LETTER_W-1:0]     held [KEY_ROWS];
  logic [2:0]              held_count;
  cipher_t                 cipher_expected [$];

  // block size in use: zero acts as one, large values clamp
  function automatic int unsigned active_size();
    int unsigned cap;
    int unsigned n;
    cap = (MAX_BLOCK < KEY_ROWS) ? MAX_BLOCK : KEY_ROWS;
    n = (size_setting == 0) ? 1 : size_setting;
    return (n > cap) ? cap : n;
  endfunction

  // take one letter; when the block closes, queue its transformed letters
  function automatic void absorb_letter(input text_t t);
    int unsigned n;
    int unsigned i;
    int unsigned j;
    int unsigned acc;
    cipher_t     c;
    n = active_size();
    held[held_count[1:0]] = t.letter_in;
    held_count = held_count + 3'd1;
    if (held_count < n && !t.message_end) return;
    for (i = held_count; i < n; i++) held[i] = LETTER_W'(PAD_LETTER);
    for (i = 0; i < n; i++) begin
      acc = 0;
      for (j = 0; j < n; j++)
        acc = (acc + (int'(key_row[i][LETTER_W*j +: LETTER_W]) * int'(held[j])) % ALPHABET)
              % ALPHABET;
      c.letter_out   = LETTER_W'(acc);
      c.block_last   = (i == n - 1);
      c.message_last = (i == n - 1) && t.message_end;
      cipher_expected.push_back(c);
    end
    held_count = '0;
  endfunction

  task automatic report(input string msg);
    failures++;
    $display("[%0t] result %0d: %s", $time, results_checked, msg);
  endtask

  // watch all three channels at each edge
  always @(posedge clk) begin
    cipher_t want;
    if (rst) begin
      size_setting = BLOCK_SIZE_W'(BLOCK_SIZE_RESET);
      for (int k = 0; k < KEY_ROWS; k++) begin
        key_row[k] = '0;
        held[k]    = '0;
      end
      held_count = '0;
      cipher_expected.delete();
    end else begin
      // compare before predicting: a result never belongs to a letter taken this edge
      if (cipher_valid && !cipher_stall) begin
        results_checked++;
        if (cipher_expected.size() == 0) begin
          report($sformatf("unexpected letter_out %0d", cipher.letter_out));
        end else begin
          want = cipher_expected.pop_front();
          if (cipher.letter_out !== want.letter_out)
            report($sformatf("letter_out %0d, expected %0d", cipher.letter_out,
                             want.letter_out));
          if (cipher.block_last !== want.block_last)
            report($sformatf("block_last %0b, expected %0b", cipher.block_last,
                             want.block_last));
          if (cipher.message_last !== want.message_last)
            report($sformatf("message_last %0b, expected %0b", cipher.message_last,
                             want.message_last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BLOCK_SIZE:    size_setting = cfg_data[BLOCK_SIZE_W-1:0];
          REG_KEY_ROW_ZERO:  key_row[0] = cfg_data;
          REG_KEY_ROW_ONE:   key_row[1] = cfg_data;
          REG_KEY_ROW_TWO:   key_row[2] = cfg_data;
          REG_KEY_ROW_THREE: key_row[3] = cfg_data;
          default: ;
        endcase
      end
      if (text_valid && !text_stall) absorb_letter(text);
    end
    expected_pending <= cipher_expected.size();
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the Hill cipher block transform testbench: clock, reset, stimulus and verdict.
module tb;

  localparam int LW     = hcbt_pkg::LETTER_W;
  localparam int KRW    = hcbt_pkg::KEY_ROW_W;
  localparam int BSW    = hcbt_pkg::BLOCK_SIZE_W;
  localparam int CIW    = hcbt_pkg::CFG_INDEX_W;
  localparam int CDW    = hcbt_pkg::CFG_DATA_W;
  localparam int HIGH_W = CDW - BSW;

  localparam int SETTLE_CYCLES = 4;
  // random phases run past this by about half a phase
  localparam int TOTAL_LETTERS = 410;
  localparam logic [CIW-1:0] FIRST_UNUSED_REG = CIW'(hcbt_pkg::REG_KEY_ROW_THREE + 1);

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                text_valid = 1'b0;
  logic                text_stall;
  hcbt_pkg::text_t     text = '0;
  logic                cipher_valid;
  logic                cipher_stall = 1'b0;
  hcbt_pkg::cipher_t   cipher;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CIW-1:0]      cfg_index = '0;
  logic [CDW-1:0]      cfg_data = '0;

  int   expected_pending;
  int   failures;
  int   results_checked;
  int   letters_sent = 0;
  int   reg_writes = 0;
  int   phases = 0;
  logic quiet = 1'b0;
  int   stall_hold = 0;

  hill_cipher_block_transform uut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text         (text),
    .cipher_valid (cipher_valid),
    .cipher_stall (cipher_stall),
    .cipher       (cipher),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  hill_block_checker u_scoreboard (
    .clk              (clk),
    .rst              (rst),
    .text_valid       (text_valid),
    .text_stall       (text_stall),
    .text             (text),
    .cipher_valid     (cipher_valid),
    .cipher_stall     (cipher_stall),
    .cipher           (cipher),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .expected_pending (expected_pending),
    .failures         (failures),
    .results_checked  (results_checked)
  );

  always #4 clk = ~clk;

  // gap length: mostly none or short, now and then long
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  // key row from four entries, column 0 in the low bits
  function automatic logic [KRW-1:0] pack_row(input int c0, input int c1, input int c2,
                                              input int c3);
    return {LW'(c3), LW'(c2), LW'(c1), LW'(c0)};
  endfunction

  function automatic logic [KRW-1:0] random_key_row();
    if ($urandom_range(0, 4) == 0) return KRW'($urandom_range(0, 20'hFFFFF));
    return pack_row($urandom_range(0, 25), $urandom_range(0, 25), $urandom_range(0, 25),
                    $urandom_range(0, 25));
  endfunction

  // receiver backpressure
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      cipher_stall <= !quiet && ($urandom_range(0, 2) == 0);
      stall_hold   <= idle_length();
    end
  end

  // one letter transaction; valid stays high if the next one follows at once
  task automatic send_letter(input int letter, input logic last);
    int gap;
    gap = idle_length();
    cfg_valid <= 1'b0;
    if (gap != 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid        <= 1'b1;
    text.letter_in    <= LW'(letter);
    text.message_end  <= last;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    letters_sent++;
  endtask

  task automatic write_reg(input logic [CIW-1:0] index, input logic [CDW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
  endtask

  // wait until every predicted result is back, then let the pipeline settle
  task automatic wait_idle();
    text_valid <= 1'b0;
    cfg_valid  <= 1'b0;
    @(posedge clk);
    while (expected_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int msg_left;
    int phase_len;
    int r;
    int letter;
    logic [BSW-1:0] size;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: size 3, zero key; short message gets padded
    send_letter(0, 1'b0);
    send_letter(25, 1'b1);
    wait_idle();

    // full key load with out-of-range entries, plus an unused index
    write_reg(hcbt_pkg::REG_BLOCK_SIZE, CDW'(4));
    write_reg(hcbt_pkg::REG_KEY_ROW_ZERO, pack_row(31, 25, 0, 1));
    write_reg(hcbt_pkg::REG_KEY_ROW_ONE, pack_row(25, 25, 25, 25));
    write_reg(hcbt_pkg::REG_KEY_ROW_TWO, pack_row(0, 31, 31, 7));
    write_reg(hcbt_pkg::REG_KEY_ROW_THREE, 20'hFFFFF);
    write_reg(FIRST_UNUSED_REG, 20'h5A5A5);
    // full block with extreme letters
    send_letter(31, 1'b0);
    send_letter(25, 1'b0);
    send_letter(0, 1'b0);
    send_letter(16, 1'b0);
    // message end on a full block: no padding
    send_letter(3, 1'b0);
    send_letter(1, 1'b0);
    send_letter(4, 1'b0);
    send_letter(1, 1'b1);
    // single letter message: three pad letters
    send_letter(2, 1'b1);
    wait_idle();

    // size zero behaves as one
    write_reg(hcbt_pkg::REG_BLOCK_SIZE, CDW'(0));
    send_letter(25, 1'b0);
    send_letter(31, 1'b1);
    wait_idle();

    // oversized setting clamps to four
    write_reg(hcbt_pkg::REG_BLOCK_SIZE, CDW'(7));
    send_letter(9, 1'b0);
    send_letter(30, 1'b1);
    // three letters held, then shrink to two: next letter closes the block
    send_letter(5, 1'b0);
    send_letter(6, 1'b0);
    send_letter(7, 1'b0);
    wait_idle();
    write_reg(hcbt_pkg::REG_BLOCK_SIZE, CDW'(2));
    send_letter(8, 1'b0);
    // one letter held, then grow to three
    send_letter(10, 1'b0);
    wait_idle();
    write_reg(hcbt_pkg::REG_BLOCK_SIZE, CDW'(3));
    send_letter(11, 1'b0);
    send_letter(12, 1'b0);

    // random phases: new settings, then messages that may straddle phases
    msg_left = 0;
    while (letters_sent < TOTAL_LETTERS) begin
      wait_idle();
      phases++;
      quiet <= ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (r < 8) size = BSW'($urandom_range(1, 4));
      else if (r == 8) size = '0;
      else size = BSW'($urandom_range(5, 7));
      write_reg(hcbt_pkg::REG_BLOCK_SIZE, {HIGH_W'($urandom_range(0, 20'h1FFFF)), size});
      if ($urandom_range(0, 1) == 0)
        write_reg(hcbt_pkg::REG_KEY_ROW_ZERO, random_key_row());
      if ($urandom_range(0, 1) == 0)
        write_reg(hcbt_pkg::REG_KEY_ROW_ONE, random_key_row());
      if ($urandom_range(0, 1) == 0)
        write_reg(hcbt_pkg::REG_KEY_ROW_TWO, random_key_row());
      if ($urandom_range(0, 1) == 0)
        write_reg(hcbt_pkg::REG_KEY_ROW_THREE, random_key_row());
      if ($urandom_range(0, 7) == 0)
        write_reg(FIRST_UNUSED_REG + CIW'($urandom_range(0, 2)),
                  CDW'($urandom_range(0, 20'hFFFFF)));
      phase_len = $urandom_range(10, 50);
      repeat (phase_len) begin
        if (msg_left == 0)
          msg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
        letter = ($urandom_range(0, 9) == 0) ? $urandom_range(26, 31) : $urandom_range(0, 25);
        msg_left--;
        send_letter(letter, msg_left == 0);
      end
    end

    wait_idle();
    $display("%0d letters in %0d random phases, %0d register writes, %0d results checked",
             letters_sent, phases, reg_writes, results_checked);
    $display("block sizes 0 to 7, padding, size changes mid-block, out-of-range letters/keys");
    if (failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/hcbt_pkg.sv
sv/hcbt_mix.sv
sv/hill_cipher_block_transform.sv
sv/hcbt_check.sv
tb/sv/hill_block_checker.sv
tb/sv/tb.sv
